>>> sv/segment_tree_range_sum_macros.svh
// assertion macros for the segment tree range sum block
// used by the top level only; expects aclk and aresetn in scope
`ifndef SEGMENT_TREE_RANGE_SUM_MACROS_SVH
`define SEGMENT_TREE_RANGE_SUM_MACROS_SVH

// same-cycle implication, held off during reset
`define STRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define STRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/strs_pkg.sv
// shared types and constants for the segment tree range sum block
// no dependencies; used by controller, datapath and top level
package strs_pkg;

    localparam int SUM_W          = 42;
    localparam int IDX_W          = 10;
    localparam int VAL_W          = 32;
    localparam int LC_W           = 11;
    localparam int LC_RESET       = 1024;
    localparam int LEAVES_DEFAULT = 1024;

    // input tdata layout, lowest bit up
    localparam int LEAF_INDEX_LSB = 0;
    localparam int LEAF_VALUE_LSB = LEAF_INDEX_LSB + IDX_W;
    localparam int RANGE_LOW_LSB  = LEAF_VALUE_LSB + VAL_W;
    localparam int RANGE_HIGH_LSB = RANGE_LOW_LSB + IDX_W;
    localparam int S_FIELDS_W     = RANGE_HIGH_LSB + IDX_W;
    localparam int S_TDATA_W      = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W      = ((SUM_W + 7) / 8) * 8;

    localparam logic ACTION_ASSIGN = 1'b0;
    localparam logic ACTION_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_ASG_LEAF,
        ST_ASG_READ,
        ST_ASG_SUM,
        ST_QRY_READ,
        ST_QRY_ACC,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear;     // write zero at clear pointer, advance
        logic load;      // latch the accepted transaction
        logic leaf_wr;   // write the new leaf value
        logic asg_sum;   // write parent sum, step up one level
        logic qry_acc;   // add boundary nodes, step both ends up
        logic out_load;  // move result into the output register
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_query;
        logic err;
        logic at_root;
        logic parent_root;
        logic a_lt_b;
        logic out_busy;
    } status_t;

endpackage

>>> sv/strs_ctrl.sv
// controller state machine for the segment tree range sum block
// depends on strs_pkg; drives the datapath by cmd_t, reads status_t
module strs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  strs_pkg::status_t status,
    output strs_pkg::cmd_t    cmd
);

    strs_pkg::state_t state_reg;
    strs_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= strs_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            strs_pkg::ST_CLEAR: begin
                if (status.clr_done) state_next = strs_pkg::ST_IDLE;
            end
            strs_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = strs_pkg::ST_DECODE;
            end
            strs_pkg::ST_DECODE: begin
                if (status.err) state_next = strs_pkg::ST_FINISH;
                else if (status.is_query) state_next = strs_pkg::ST_QRY_READ;
                else state_next = strs_pkg::ST_ASG_LEAF;
            end
            strs_pkg::ST_ASG_LEAF: begin
                state_next = status.at_root ? strs_pkg::ST_FINISH : strs_pkg::ST_ASG_READ;
            end
            strs_pkg::ST_ASG_READ: begin
                state_next = strs_pkg::ST_ASG_SUM;
            end
            strs_pkg::ST_ASG_SUM: begin
                state_next = status.parent_root ? strs_pkg::ST_FINISH : strs_pkg::ST_ASG_READ;
            end
            strs_pkg::ST_QRY_READ: begin
                state_next = status.a_lt_b ? strs_pkg::ST_QRY_ACC : strs_pkg::ST_FINISH;
            end
            strs_pkg::ST_QRY_ACC: begin
                state_next = strs_pkg::ST_QRY_READ;
            end
            strs_pkg::ST_FINISH: begin
                if (!status.out_busy) state_next = strs_pkg::ST_IDLE;
            end
            default: begin
                state_next = strs_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            strs_pkg::ST_CLEAR: begin
                cmd.clear = 1'b1;
            end
            strs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            strs_pkg::ST_ASG_LEAF: begin
                cmd.leaf_wr = 1'b1;
            end
            strs_pkg::ST_ASG_SUM: begin
                cmd.asg_sum = 1'b1;
            end
            strs_pkg::ST_QRY_ACC: begin
                cmd.qry_acc = 1'b1;
            end
            strs_pkg::ST_FINISH: begin
                cmd.out_load = !status.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/strs_datapath.sv
// datapath of the segment tree range sum block: node memory, walk registers,
// accumulator, config register and output register; depends on strs_pkg
module strs_datapath #(
    parameter int LEAVES = strs_pkg::LEAVES_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [strs_pkg::LC_W-1:0]      cfg_wdata,
    input  logic [strs_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [strs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser,
    input  strs_pkg::cmd_t                 cmd,
    output strs_pkg::status_t              status
);

    localparam int NW    = $clog2(2 * LEAVES);
    localparam int AW    = NW + 1;
    localparam int DEPTH = 2 * LEAVES;

    logic [strs_pkg::SUM_W-1:0] mem [DEPTH];

    logic [strs_pkg::LC_W-1:0]  leaf_count_reg;
    logic                       is_query_reg;
    logic                       err_reg;
    logic [NW-1:0]              p_reg;
    logic [AW-1:0]              a_reg;
    logic [AW-1:0]              b_reg;
    logic [strs_pkg::SUM_W-1:0] cur_reg;
    logic [strs_pkg::SUM_W-1:0] acc_reg;
    logic [NW-1:0]              clr_reg;
    logic [strs_pkg::SUM_W-1:0] rd_a_reg;
    logic [strs_pkg::SUM_W-1:0] rd_b_reg;
    logic                       m_tvalid_reg;
    logic [strs_pkg::SUM_W-1:0] m_sum_reg;
    logic                       m_err_reg;

    logic [NW-1:0]              eff_n;
    logic [strs_pkg::IDX_W-1:0] leaf_index;
    logic [strs_pkg::VAL_W-1:0] leaf_value;
    logic [strs_pkg::IDX_W-1:0] range_low;
    logic [strs_pkg::IDX_W-1:0] range_high;
    logic                       load_err;
    logic [strs_pkg::SUM_W-1:0] parent_sum;
    logic [strs_pkg::SUM_W-1:0] term_a;
    logic [strs_pkg::SUM_W-1:0] term_b;
    logic [AW-1:0]              b_minus_one;
    logic [NW-1:0]              rd_a_addr;
    logic [NW-1:0]              rd_b_addr;
    logic                       mem_we;
    logic [NW-1:0]              mem_wa;
    logic [strs_pkg::SUM_W-1:0] mem_wd;

    assign leaf_index = s_tdata[strs_pkg::LEAF_INDEX_LSB +: strs_pkg::IDX_W];
    assign leaf_value = s_tdata[strs_pkg::LEAF_VALUE_LSB +: strs_pkg::VAL_W];
    assign range_low  = s_tdata[strs_pkg::RANGE_LOW_LSB +: strs_pkg::IDX_W];
    assign range_high = s_tdata[strs_pkg::RANGE_HIGH_LSB +: strs_pkg::IDX_W];

    // zero acts as one leaf, anything above the tree size is clamped
    always_comb begin
        if (leaf_count_reg == '0) begin
            eff_n = NW'(1);
        end else if (32'(leaf_count_reg) > 32'(LEAVES)) begin
            eff_n = NW'(LEAVES);
        end else begin
            eff_n = NW'(leaf_count_reg);
        end
    end

    always_comb begin
        if (s_tuser == strs_pkg::ACTION_QUERY) begin
            load_err = (32'(range_low) >= 32'(eff_n)) || (32'(range_high) >= 32'(eff_n));
        end else begin
            load_err = 32'(leaf_index) >= 32'(eff_n);
        end
    end

    assign parent_sum  = cur_reg + rd_a_reg;
    assign term_a      = a_reg[0] ? rd_a_reg : '0;
    assign term_b      = b_reg[0] ? rd_b_reg : '0;
    assign b_minus_one = b_reg - AW'(1);
    assign rd_a_addr   = is_query_reg ? a_reg[NW-1:0] : (p_reg ^ NW'(1));
    assign rd_b_addr   = b_minus_one[NW-1:0];

    always_comb begin
        mem_we = 1'b0;
        mem_wa = clr_reg;
        mem_wd = '0;
        if (cmd.clear) begin
            mem_we = 1'b1;
        end else if (cmd.leaf_wr) begin
            mem_we = 1'b1;
            mem_wa = p_reg;
            mem_wd = cur_reg;
        end else if (cmd.asg_sum) begin
            mem_we = 1'b1;
            mem_wa = p_reg >> 1;
            mem_wd = parent_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leaf_count_reg <= strs_pkg::LC_W'(strs_pkg::LC_RESET);
            clr_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_we) leaf_count_reg <= cfg_wdata;
            if (cmd.clear) clr_reg <= clr_reg + NW'(1);
            if (cmd.out_load) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            is_query_reg <= s_tuser;
            err_reg      <= load_err;
            p_reg        <= NW'(leaf_index) + eff_n;
            a_reg        <= AW'(range_low) + AW'(eff_n);
            b_reg        <= AW'(range_high) + AW'(eff_n) + AW'(1);
            cur_reg      <= strs_pkg::SUM_W'(leaf_value);
            acc_reg      <= '0;
        end else if (cmd.asg_sum) begin
            cur_reg <= parent_sum;
            p_reg   <= p_reg >> 1;
        end else if (cmd.qry_acc) begin
            acc_reg <= acc_reg + term_a + term_b;
            a_reg   <= (a_reg + AW'(a_reg[0])) >> 1;
            b_reg   <= (b_reg - AW'(b_reg[0])) >> 1;
        end
        if (cmd.out_load) begin
            m_sum_reg <= acc_reg;
            m_err_reg <= err_reg;
        end
    end

    assign status.clr_done    = clr_reg == NW'(DEPTH - 1);
    assign status.is_query    = is_query_reg;
    assign status.err         = err_reg;
    assign status.at_root     = p_reg == NW'(1);
    assign status.parent_root = (p_reg >> 1) == NW'(1);
    assign status.a_lt_b      = a_reg < b_reg;
    assign status.out_busy    = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = strs_pkg::M_TDATA_W'(m_sum_reg);
    assign m_tuser  = m_err_reg;

endmodule

>>> sv/segment_tree_range_sum.sv
// segment tree range sum, top level; depends on strs_pkg, strs_ctrl, strs_datapath
// assign walks from the leaf up to the root; query walks both ends up, level by level,
//   until the two ends meet
// one transaction in flight; each tree level costs a read and an add on the node memory
// a new transaction is taken only once the last is done; a waiting result does not block input
// reset: synchronous active low; then the node memory is cleared, s_tready low
`include "segment_tree_range_sum_macros.svh"

module segment_tree_range_sum #(
    parameter int LEAVES = strs_pkg::LEAVES_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [strs_pkg::LC_W-1:0]      cfg_wdata,   // leaf_count
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [strs_pkg::S_TDATA_W-1:0] s_tdata,     // leaf_index, leaf_value, range_low, range_high
    input  logic                           s_tuser,     // action
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [strs_pkg::M_TDATA_W-1:0] m_tdata,     // range_sum
    output logic                           m_tuser      // index_error
);

    strs_pkg::cmd_t    cmd;
    strs_pkg::status_t status;

    strs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    strs_datapath #(
        .LEAVES (LEAVES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

    `STRS_ASSERT_NOW(a_no_accept_in_clear, cmd.clear, !s_tready, "input ready during memory clear")
    `STRS_ASSERT_NOW(a_out_slot_free, cmd.out_load, !m_tvalid || m_tready, "result overwrote pending output")
    `STRS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second transaction taken while busy")
    `STRS_ASSERT_NOW(a_no_write_when_ready, cmd.leaf_wr || cmd.asg_sum, !s_tready, "tree write while idle")

endmodule
